// ===== src/tcw_pkg.sv =====
`default_nettype none

package tcw_pkg;

	localparam int ROWS_DEFAULT = 25;
	localparam int COLS_DEFAULT = 80;

	localparam int CMD_W      = 2;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 3;
	localparam int ROW_PORT_W = 5;
	localparam int COL_PORT_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] KEEP_MASK = 8'h8F;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT     = 2'd0,
		CMD_CLEAR   = 2'd1,
		CMD_RECOLOR = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FOREGROUND = 2'd0,
		CFG_BACKGROUND = 2'd1,
		CFG_BRIGHT     = 2'd2,
		CFG_BLINK      = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SWEEP_ZERO    = 2'd0,
		SWEEP_SCROLL  = 2'd1,
		SWEEP_CLEAR   = 2'd2,
		SWEEP_RECOLOR = 2'd3
	} sweep_kind_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_SWEEP = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

`default_nettype wire

// ===== src/text_console_writer.sv =====
// Text console engine: a ROWS x COLS screen of character and attribute bytes in two
// single-port-write synchronous memories, plus a cursor. Put-char (with LF and CR),
// read-cell and the cursor update go through the EXEC state, with its memory access, and
// then DONE, which loads the result register. Clear, recolor and the scroll that follows
// a put past the last row walk the whole screen one cell per cycle through a single
// read/write sweep. After reset a clearing pass zeroes the screen; req_stall stays high
// during it, configuration writes are taken at any time. A finished result waits in the
// output register while the next request is accepted.
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int ROWS = ROWS_DEFAULT,
	parameter int COLS = COLS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  req_valid,
	output      logic                  req_stall,
	input  wire logic [CMD_W-1:0]      command,
	input  wire logic [CHAR_W-1:0]     char_code,
	input  wire logic [COLOR_W-1:0]    new_background,
	input  wire logic [ROW_PORT_W-1:0] read_row,
	input  wire logic [COL_PORT_W-1:0] read_column,

	output      logic                  res_valid,
	input  wire logic                  res_stall,
	output      logic [ROW_PORT_W-1:0] cursor_row,
	output      logic [COL_PORT_W-1:0] cursor_column,
	output      logic [CHAR_W-1:0]     cell_char,
	output      logic [CHAR_W-1:0]     cell_attribute
);

	localparam int CELLS      = ROWS * COLS;
	localparam int ADDR_W     = $clog2(CELLS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLS);
	localparam int IDX_W      = ROW_PORT_W + COL_PORT_W + 1;
	localparam int SCROLL_END = CELLS - COLS;

	localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLS - 1);
	localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'(SCROLL_END);
	localparam logic [ADDR_W-1:0] COLS_A        = ADDR_W'(COLS);

	logic [CHAR_W-1:0] char_mem [CELLS];
	logic [CHAR_W-1:0] attr_mem [CELLS];
	logic [CHAR_W-1:0] char_rd_q, attr_rd_q;

	state_t            state_q;
	sweep_kind_t       kind_q;
	logic [ADDR_W-1:0] sw_q;
	logic              wr_v_s1, src_ok_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [ADDR_W-1:0] cur_addr_q;

	logic [COLOR_W-1:0] fg_q, bg_q;
	logic               bright_q, blink_q;

	cmd_t                cmd_q;
	logic [CHAR_W-1:0]   char_q;
	logic [COLOR_W-1:0]  nbg_q;
	logic [ROW_PORT_W-1:0] rrow_q;
	logic [COL_PORT_W-1:0] rcol_q;

	logic                  res_valid_q;
	logic [ROW_PORT_W-1:0] res_row_q;
	logic [COL_PORT_W-1:0] res_col_q;
	logic [CHAR_W-1:0]     res_char_q, res_attr_q;

	logic              req_take, done_fire, in_range, put_print, wrap, scroll_need;
	logic [IDX_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] raddr, waddr, sw_src;
	logic              we_char, we_attr;
	logic [CHAR_W-1:0] wchar, wattr, put_attr;
	logic [ROW_W+ROW_PORT_W-1:0] row_ext;
	logic [COL_W+COL_PORT_W-1:0] col_ext;

	assign done_fire = (state_q == ST_DONE) && (!res_valid_q || !res_stall);
	assign req_stall = !((state_q == ST_IDLE) || done_fire);
	assign req_take  = req_valid && !req_stall;

	assign in_range = ({3'b000, rrow_q} < 8'(ROWS)) && ({1'b0, rcol_q} < 8'(COLS));
	assign rd_idx   = IDX_W'(rrow_q) * IDX_W'(COLS) + IDX_W'(rcol_q);
	assign sw_src   = (kind_q == SWEEP_SCROLL) ? sw_q + COLS_A : sw_q;
	assign put_attr = {blink_q, bg_q, bright_q, fg_q};

	assign put_print   = (cmd_q == CMD_PUT) && (char_q != CH_LF) && (char_q != CH_CR);
	assign wrap        = (char_q == CH_LF) || (put_print && (col_q == LAST_COL));
	assign scroll_need = wrap && (row_q == LAST_ROW);

	always_comb begin
		raddr = in_range ? ADDR_W'(rd_idx) : '0;
		if (state_q == ST_SWEEP) begin
			raddr = sw_src;
		end
		we_char = 1'b0;
		we_attr = 1'b0;
		waddr   = wr_addr_s1;
		wchar   = '0;
		wattr   = '0;
		if (wr_v_s1) begin
			case (kind_q)
				SWEEP_SCROLL: begin
					we_char = 1'b1;
					we_attr = 1'b1;
					wchar   = src_ok_s1 ? char_rd_q : '0;
					wattr   = src_ok_s1 ? attr_rd_q : '0;
				end
				SWEEP_CLEAR: begin
					we_char = 1'b1;
					wchar   = CH_SPACE;
				end
				SWEEP_RECOLOR: begin
					we_attr = 1'b1;
					wattr   = (attr_rd_q & KEEP_MASK) | {1'b0, nbg_q, 4'b0000};
				end
				default: begin
					we_char = 1'b1;
					we_attr = 1'b1;
				end
			endcase
		end else if ((state_q == ST_EXEC) && put_print) begin
			we_char = 1'b1;
			we_attr = 1'b1;
			waddr   = cur_addr_q;
			wchar   = char_q;
			wattr   = put_attr;
		end
	end

	always_ff @(posedge clk) begin
		if (we_char) begin
			char_mem[waddr] <= wchar;
		end
		if (we_attr) begin
			attr_mem[waddr] <= wattr;
		end
		char_rd_q <= char_mem[raddr];
		attr_rd_q <= attr_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q     <= 3'd7;
			bg_q     <= '0;
			bright_q <= 1'b0;
			blink_q  <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FOREGROUND: fg_q     <= cfg_data;
				CFG_BACKGROUND: bg_q     <= cfg_data;
				CFG_BRIGHT:     bright_q <= cfg_data[0];
				CFG_BLINK:      blink_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q  <= cmd_t'(command);
			char_q <= char_code;
			nbg_q  <= new_background;
			rrow_q <= read_row;
			rcol_q <= read_column;
		end
		wr_addr_s1 <= sw_q;
		src_ok_s1  <= (32'(sw_q) < SCROLL_END);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			kind_q     <= SWEEP_ZERO;
			sw_q       <= '0;
			wr_v_s1    <= 1'b0;
			row_q      <= '0;
			col_q      <= '0;
			cur_addr_q <= '0;
		end else begin
			wr_v_s1 <= (state_q == ST_SWEEP);
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					sw_q    <= '0;
					state_q <= ST_DONE;
					unique case (cmd_q)
						CMD_PUT: begin
							if (scroll_need) begin
								row_q      <= LAST_ROW;
								col_q      <= '0;
								cur_addr_q <= LAST_ROW_BASE;
								kind_q     <= SWEEP_SCROLL;
								state_q    <= ST_SWEEP;
							end else if (char_q == CH_LF) begin
								row_q      <= row_q + 1'b1;
								col_q      <= '0;
								cur_addr_q <= cur_addr_q - ADDR_W'(col_q) + COLS_A;
							end else if (char_q == CH_CR) begin
								col_q      <= '0;
								cur_addr_q <= cur_addr_q - ADDR_W'(col_q);
							end else begin
								if (wrap) begin
									row_q <= row_q + 1'b1;
									col_q <= '0;
								end else begin
									col_q <= col_q + 1'b1;
								end
								cur_addr_q <= cur_addr_q + 1'b1;
							end
						end
						CMD_CLEAR: begin
							row_q      <= '0;
							col_q      <= '0;
							cur_addr_q <= '0;
							kind_q     <= SWEEP_CLEAR;
							state_q    <= ST_SWEEP;
						end
						CMD_RECOLOR: begin
							kind_q  <= SWEEP_RECOLOR;
							state_q <= ST_SWEEP;
						end
						default: ;
					endcase
				end
				ST_SWEEP: begin
					sw_q <= sw_q + 1'b1;
					if (sw_q == LAST_CELL) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= (kind_q == SWEEP_ZERO) ? ST_IDLE : ST_DONE;
				end
				ST_DONE: begin
					if (req_take) begin
						state_q <= ST_EXEC;
					end else if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign row_ext = (ROW_W + ROW_PORT_W)'(row_q);
	assign col_ext = (COL_W + COL_PORT_W)'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done_fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			res_row_q  <= row_ext[ROW_PORT_W-1:0];
			res_col_q  <= col_ext[COL_PORT_W-1:0];
			res_char_q <= ((cmd_q == CMD_READ) && in_range) ? char_rd_q : '0;
			res_attr_q <= ((cmd_q == CMD_READ) && in_range) ? attr_rd_q : '0;
		end
	end

	assign res_valid      = res_valid_q;
	assign cursor_row     = res_row_q;
	assign cursor_column  = res_col_q;
	assign cell_char      = res_char_q;
	assign cell_attribute = res_attr_q;

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(row_q <= LAST_ROW) && (col_q <= LAST_COL))
		else $error("cursor left the screen");

	a_cursor_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
		(32'(cur_addr_q) == 32'(row_q) * COLS + 32'(col_q)))
		else $error("cursor address out of step with row and column");

	a_sweep_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_v_s1 |-> $past(state_q == ST_SWEEP))
		else $error("sweep write without a sweep read");

endmodule

`default_nettype wire
